// ===== sv/mrh_pkg.sv =====
package mrh_pkg;

  localparam int unsigned DATA_W     = 64;
  localparam int unsigned TAIL_W     = 4;
  localparam int unsigned S_TDATA_W  = 72;
  localparam int unsigned ROT_LEFT   = 31;
  localparam int unsigned FMIX_SHIFT = 33;

  localparam logic [DATA_W-1:0] HASH_SEED = 64'h1656679197377081;
  localparam logic [DATA_W-1:0] MIX_PRIME = 64'h9E3779B97F4A7C15;
  localparam logic [DATA_W-1:0] FMIX_C1   = 64'hFF51AFD7ED558CCD;
  localparam logic [DATA_W-1:0] FMIX_C2   = 64'hC4CEB9FE1A85EC53;

  localparam logic [TAIL_W-1:0] FULL_TAIL = 4'd8;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [DATA_W-1:0] word;    // tail bytes already masked
    logic [TAIL_W-1:0] tail;    // bytes counted into the length (8 unless last)
    logic              absorb;  // full word: multiply and rotate
    logic              last;    // finalise after this word
  } mrh_entry_t;

endpackage

// ===== sv/mrh_front.sv =====
module mrh_front
  import mrh_pkg::*;
(
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  input  logic                 q_full,
  output logic                 q_push,
  output mrh_entry_t           q_entry
);

  logic [TAIL_W-1:0] tail_in;
  logic [TAIL_W-1:0] tail_sat;
  logic [TAIL_W-1:0] tail_eff;
  logic              absorb;
  logic [DATA_W-1:0] mask;

  assign tail_in  = s_tdata[DATA_W +: TAIL_W];
  assign tail_sat = (tail_in > FULL_TAIL) ? FULL_TAIL : tail_in;
  // A word that is not the last always counts as eight bytes.
  assign tail_eff = s_tlast ? tail_sat : FULL_TAIL;
  assign absorb   = (tail_eff == FULL_TAIL);

  always_comb begin
    for (int i = 0; i < DATA_W / 8; i++) begin
      mask[i*8 +: 8] = (absorb || (TAIL_W'(i) < tail_eff)) ? 8'hFF : 8'h00;
    end
  end

  assign s_tready       = !q_full;
  assign q_push         = s_tvalid && !q_full;
  assign q_entry.word   = s_tdata[DATA_W-1:0] & mask;
  assign q_entry.tail   = tail_eff;
  assign q_entry.absorb = absorb;
  assign q_entry.last   = s_tlast;

endmodule

// ===== sv/mrh_queue.sv =====
module mrh_queue
  import mrh_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  mrh_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output mrh_entry_t pop_entry,
  output logic       empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  mrh_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

endmodule

// ===== sv/mrh_back.sv =====
module mrh_back
  import mrh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  mrh_entry_t        q_entry,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [1:0] PASS_ABS = 2'd0;
  localparam logic [1:0] PASS_F1  = 2'd1;
  localparam logic [1:0] PASS_F2  = 2'd2;

  localparam logic [1:0] STEP_LAST = 2'd3;

  function automatic logic [DATA_W-1:0] shift_xor(input logic [DATA_W-1:0] x);
    shift_xor = x ^ (x >> FMIX_SHIFT);
  endfunction

  function automatic logic [DATA_W-1:0] rotl(input logic [DATA_W-1:0] x);
    rotl = (x << ROT_LEFT) | (x >> (DATA_W - ROT_LEFT));
  endfunction

  logic [1:0]        state;
  logic [1:0]        step;
  logic [1:0]        pass;
  logic              ent_last;
  logic [DATA_W-1:0] opnd;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] len;

  logic [DATA_W-1:0] konst;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [DATA_W-1:0] prod_next;
  logic [DATA_W-1:0] mul_res;
  logic [DATA_W-1:0] len_plus;
  logic [DATA_W-1:0] rot_res;
  logic              out_free;

  always_comb begin
    unique case (pass)
      PASS_ABS: konst = MIX_PRIME;
      PASS_F1:  konst = FMIX_C1;
      default:  konst = FMIX_C2;
    endcase
  end

  // Low half of a 64x64 product from three 32x32 partial products.
  assign mul_a     = (step == 2'd1) ? opnd[63:32] : opnd[31:0];
  assign mul_b     = (step == 2'd2) ? konst[63:32] : konst[31:0];
  assign prod_next = mul_a * mul_b;
  assign mul_res   = {sum[63:32] + prod[31:0], sum[31:0]};
  assign rot_res   = rotl(mul_res);

  assign len_plus = len + DATA_W'(q_entry.tail);
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
      acc      <= HASH_SEED;
      len      <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            len      <= len_plus;
            ent_last <= q_entry.last;
            step     <= '0;
            state    <= S_MUL;
            if (q_entry.absorb) begin
              opnd <= acc ^ q_entry.word;
              pass <= PASS_ABS;
            end else begin
              opnd <= shift_xor(acc ^ q_entry.word ^ len_plus);
              pass <= PASS_F1;
            end
          end
        end
        S_MUL: begin
          prod <= prod_next;
          step <= step + 1'b1;
          unique case (step)
            2'd0: ;
            2'd1: sum <= prod;
            2'd2: sum[63:32] <= sum[63:32] + prod[31:0];
            default: begin
              unique case (pass)
                PASS_ABS: begin
                  if (ent_last) begin
                    opnd <= shift_xor(rot_res ^ len);
                    pass <= PASS_F1;
                  end else begin
                    acc   <= rot_res;
                    state <= S_IDLE;
                  end
                end
                PASS_F1: begin
                  opnd <= shift_xor(mul_res);
                  pass <= PASS_F2;
                end
                default: begin
                  opnd  <= shift_xor(mul_res);
                  state <= S_FIN;
                end
              endcase
            end
          endcase
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= opnd;
            acc      <= HASH_SEED;
            len      <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_reseed: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (acc == HASH_SEED && len == '0 && m_tvalid))
    else $error("hash issued without reseeding");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_MUL && step == '0))
    else $error("popped word did not start a multiply");

  a_step_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && step != STEP_LAST) |=>
      (state == S_MUL && step == 2'($past(step) + 2'd1)))
    else $error("multiply sequence broken");

endmodule

// ===== sv/word_multiply_rotate_hash64.sv =====
// Streaming 64-bit multiply-rotate hash with an fmix64 finaliser. A message
// arrives as little-endian 64-bit words on the slave stream, one transaction
// per word, with tlast on the final word and its valid byte count (0 to 8,
// larger values taken as 8) in tdata[67:64]; earlier words always count as
// eight bytes. Each full word is XORed into the accumulator, multiplied by the
// golden-ratio constant and rotated left by 31; a partial final word is XORed
// in lane by lane without a multiply. The byte length is then XORed in, the
// fmix64 finaliser is applied, and one 64-bit hash is sent on the master
// stream, after which the block reseeds for the next message. Words are first
// classified and masked, then wait in a small queue (QUEUE_DEPTH entries) for
// the arithmetic engine, so the input side keeps accepting, until the queue
// fills, while the engine is busy or a finished hash waits to be taken. The
// engine has a single 32x32 multiplier and builds each 64-bit product from
// three partial products: a full word takes one multiply pass, a final word
// with 1 to 7 bytes (or none) two and a final full word three, and a finished
// hash also waits in the engine until the output register is free.
module word_multiply_rotate_hash64
  import mrh_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // data_word [63:0], tail_bytes [67:64], zero [71:68]
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // hash_value [63:0]
  output logic [DATA_W-1:0]    m_tdata
);

  // Classified words between the front end and the arithmetic engine.
  mrh_entry_t push_entry;
  mrh_entry_t pop_entry;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  mrh_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  mrh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // The engine owns the accumulator, the byte count and the output register.
  mrh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
